### rtl/vslr_pkg.sv
// ----------------------------------------------------------------------------
// vslr_pkg
// Shared types and constants for the variable-speed linear resampler.
// ----------------------------------------------------------------------------
package vslr_pkg;

    // sample width default
    localparam int SAMPLE_BITS_DEF = 24;

    // configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_SPEED   = 1'b0;    // register index from paddr[2]

    // speed register, hundredths of a frame per output
    localparam int         SPEED_BITS  = 8;
    localparam logic [7:0] SPEED_RESET = 8'd100;
    localparam logic [7:0] SPEED_MIN   = 8'd2;
    localparam logic [7:0] SPEED_MAX   = 8'd200;

    // read position in hundredths
    localparam int         PHASE_BITS = 9;
    localparam int         FRAC_BITS  = 7;
    localparam logic [9:0] UNIT       = 10'd100;

    // divide by one hundred
    localparam int          REM_BITS        = 7;
    localparam logic [7:0]  DIVISOR         = 8'd100;
    localparam int          FDR_BITS        = 14;
    localparam int          RECIP_PROD_BITS = 27;
    localparam logic [12:0] DIV100_RECIP    = 13'd5243;
    localparam int          DIV100_SHIFT    = 19;
    localparam int          CORR_BITS       = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_FIX,
        S_MUL1,
        S_MUL2,
        S_SUM
    } vslr_state_t;

    typedef struct packed {
        logic capture;    // take the new frame, start the difference
        logic prime;      // first frame: keep it, mark a frame seen
        logic div_step;   // reciprocal multiply for the quotient
        logic div_fix;    // remainder, then floor correction of both
        logic mul1;       // frac times quotient and remainder
        logic mul2;       // reciprocal of the remainder product
        logic sum_load;   // load the output register
        logic advance;    // phase plus speed
        logic finish;     // phase minus one frame, frame becomes previous
    } vslr_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic phase_ge_unit;
        logic last_out;
        logic out_free;
    } vslr_status_t;

endpackage

### rtl/vslr_chan.sv
// ----------------------------------------------------------------------------
// vslr_chan
// One channel: previous frame, difference divide by 100 and interpolation.
// ----------------------------------------------------------------------------
module vslr_chan #(
    parameter int SAMPLE_BITS = vslr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  vslr_pkg::vslr_cmd_t                 cmd,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [vslr_pkg::FRAC_BITS-1:0]      frac,
    output logic signed [SAMPLE_BITS-1:0]       value
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = SAMPLE_BITS + 9;

    // floor(x/100) as (x * ceil(2^QS/100)) >> QS, exact for x below 2^SAMPLE_BITS
    localparam int              QS      = SAMPLE_BITS + vslr_pkg::REM_BITS;
    localparam int              QP_BITS = QS + SAMPLE_BITS;
    localparam longint unsigned QR_VAL  = ((64'd1 << QS) + 64'(vslr_pkg::DIVISOR) - 64'd1)
                                        / 64'(vslr_pkg::DIVISOR);
    localparam logic [SAMPLE_BITS:0] Q_RECIP = (SAMPLE_BITS+1)'(QR_VAL);

    logic signed [SAMPLE_BITS-1:0]           prev_reg, prev_next;
    logic signed [SAMPLE_BITS-1:0]           cur_reg;
    logic [SAMPLE_BITS-1:0]                  mag_reg;
    logic [SAMPLE_BITS-1:0]                  quo_reg;
    logic                                    neg_reg;
    logic signed [DW-1:0]                    dq_reg;
    logic [vslr_pkg::REM_BITS-1:0]           dr_reg;
    logic signed [PW-1:0]                    fdq_reg;
    logic [vslr_pkg::FDR_BITS-1:0]           fdr_reg;
    logic [vslr_pkg::CORR_BITS-1:0]          t_reg;

    logic signed [DW-1:0]                    diff;
    logic signed [DW-1:0]                    mag;
    logic [QP_BITS-1:0]                      q_prod;
    logic [vslr_pkg::REM_BITS-1:0]           quo_x100;
    logic [vslr_pkg::REM_BITS-1:0]           rem;
    logic signed [DW-1:0]                    qs;
    logic [vslr_pkg::RECIP_PROD_BITS-1:0]    recip_prod;
    logic signed [PW-1:0]                    sum;

    assign diff = $signed({sample[SAMPLE_BITS-1], sample})
                - $signed({prev_reg[SAMPLE_BITS-1], prev_reg});
    assign mag  = diff[DW-1] ? -diff : diff;

    // quotient of the magnitude by reciprocal multiply
    assign q_prod = QP_BITS'(mag_reg) * QP_BITS'(Q_RECIP);

    // remainder is below 128, so the low bits of mag - 100*q are enough
    assign quo_x100 = vslr_pkg::REM_BITS'({quo_reg, 6'b0})
                    + vslr_pkg::REM_BITS'({quo_reg, 5'b0})
                    + vslr_pkg::REM_BITS'({quo_reg, 2'b0});
    assign rem      = mag_reg[vslr_pkg::REM_BITS-1:0] - quo_x100;

    assign qs = $signed({1'b0, quo_reg});

    assign recip_prod = vslr_pkg::RECIP_PROD_BITS'(fdr_reg)
                      * vslr_pkg::RECIP_PROD_BITS'(vslr_pkg::DIV100_RECIP);

    // a + f*dq + floor(f*dr/100)
    assign sum = $signed({{(PW-SAMPLE_BITS){prev_reg[SAMPLE_BITS-1]}}, prev_reg})
               + fdq_reg
               + $signed({{(PW-vslr_pkg::CORR_BITS){1'b0}}, t_reg});
    assign value = sum[SAMPLE_BITS-1:0];

    assign prev_next = (cmd.prime || cmd.finish) ? cur_reg : prev_reg;

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        if (cmd.capture)
        begin
            cur_reg <= sample;
            mag_reg <= mag[SAMPLE_BITS-1:0];
            neg_reg <= diff[DW-1];
        end
        if (cmd.div_step)
        begin
            quo_reg <= q_prod[QS +: SAMPLE_BITS];
        end
        if (cmd.div_fix)
        begin
            if (neg_reg && (rem != '0))
            begin
                dq_reg <= -qs - DW'(1);
                dr_reg <= vslr_pkg::REM_BITS'(vslr_pkg::DIVISOR - {1'b0, rem});
            end
            else if (neg_reg)
            begin
                dq_reg <= -qs;
                dr_reg <= '0;
            end
            else
            begin
                dq_reg <= qs;
                dr_reg <= rem;
            end
        end
        if (cmd.mul1)
        begin
            fdq_reg <= $signed({1'b0, frac}) * dq_reg;
            fdr_reg <= vslr_pkg::FDR_BITS'(frac) * vslr_pkg::FDR_BITS'(dr_reg);
        end
        if (cmd.mul2)
        begin
            t_reg <= recip_prod[vslr_pkg::DIV100_SHIFT +: vslr_pkg::CORR_BITS];
        end
    end

endmodule

### rtl/vslr_dp.sv
// ----------------------------------------------------------------------------
// vslr_dp
// Datapath: read position, two channels and the output register.
// ----------------------------------------------------------------------------
module vslr_dp #(
    parameter int SAMPLE_BITS = vslr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vslr_pkg::vslr_cmd_t                  cmd,
    output vslr_pkg::vslr_status_t               status,
    input  logic [vslr_pkg::SPEED_BITS-1:0]      speed,
    input  logic signed [SAMPLE_BITS-1:0]        sample_left,
    input  logic signed [SAMPLE_BITS-1:0]        sample_right,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_BITS-1:0]        out_left,
    output logic signed [SAMPLE_BITS-1:0]        out_right,
    output logic                                 last_of_run
);

    logic [vslr_pkg::PHASE_BITS-1:0]   phase_reg, phase_next;
    logic                              have_reg, have_next;
    logic                              ovalid_reg, ovalid_next;
    logic signed [SAMPLE_BITS-1:0]     oleft_reg, oright_reg;
    logic                              olast_reg;

    logic [vslr_pkg::SPEED_BITS-1:0]   speed_eff;
    logic [vslr_pkg::PHASE_BITS:0]     phase_adv;
    logic [vslr_pkg::PHASE_BITS:0]     phase_end;
    logic signed [SAMPLE_BITS-1:0]     val_left, val_right;

    always_comb
    begin
        if (speed < vslr_pkg::SPEED_MIN)
            speed_eff = vslr_pkg::SPEED_MIN;
        else if (speed > vslr_pkg::SPEED_MAX)
            speed_eff = vslr_pkg::SPEED_MAX;
        else
            speed_eff = speed;
    end

    assign phase_adv = {1'b0, phase_reg}
                     + (cmd.advance ? (vslr_pkg::PHASE_BITS+1)'(speed_eff) : '0);
    assign phase_end = cmd.finish ? (phase_adv - vslr_pkg::UNIT) : phase_adv;
    assign phase_next = phase_end[vslr_pkg::PHASE_BITS-1:0];

    assign have_next   = have_reg | cmd.prime;
    assign ovalid_next = cmd.sum_load ? 1'b1 : (out_ready ? 1'b0 : ovalid_reg);

    assign status.have_prev     = have_reg;
    assign status.phase_ge_unit = ({1'b0, phase_reg} >= vslr_pkg::UNIT);
    assign status.last_out      = (({1'b0, phase_reg} + (vslr_pkg::PHASE_BITS+1)'(speed_eff))
                                   >= vslr_pkg::UNIT);
    assign status.out_free      = !ovalid_reg || out_ready;

    vslr_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
        .clk    (clk),
        .cmd    (cmd),
        .sample (sample_left),
        .frac   (phase_reg[vslr_pkg::FRAC_BITS-1:0]),
        .value  (val_left)
    );

    vslr_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
        .clk    (clk),
        .cmd    (cmd),
        .sample (sample_right),
        .frac   (phase_reg[vslr_pkg::FRAC_BITS-1:0]),
        .value  (val_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            have_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            have_reg   <= have_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            oleft_reg  <= val_left;
            oright_reg <= val_right;
            olast_reg  <= status.last_out;
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_left    = oleft_reg;
    assign out_right   = oright_reg;
    assign last_of_run = olast_reg;

`ifndef NO_ASSERTIONS
    // position never reaches three frames past the previous one
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, phase_reg} < 10'd300)
        else $error("read position out of range");
`endif

endmodule

### rtl/vslr_ctrl.sv
// ----------------------------------------------------------------------------
// vslr_ctrl
// Sequencer: priming, the divide and one output per pass through two multiply states and the load.
// ----------------------------------------------------------------------------
module vslr_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  vslr_pkg::vslr_status_t   status,
    output vslr_pkg::vslr_cmd_t      cmd
);

    vslr_pkg::vslr_state_t  state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vslr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            vslr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = vslr_pkg::S_DECIDE;
                end
            end
            vslr_pkg::S_DECIDE:
            begin
                if (!status.have_prev)
                begin
                    cmd.prime  = 1'b1;
                    state_next = vslr_pkg::S_IDLE;
                end
                else if (status.phase_ge_unit)
                begin
                    cmd.finish = 1'b1;
                    state_next = vslr_pkg::S_IDLE;
                end
                else
                begin
                    state_next = vslr_pkg::S_DIV;
                end
            end
            vslr_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = vslr_pkg::S_FIX;
            end
            vslr_pkg::S_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = vslr_pkg::S_MUL1;
            end
            vslr_pkg::S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = vslr_pkg::S_MUL2;
            end
            vslr_pkg::S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = vslr_pkg::S_SUM;
            end
            vslr_pkg::S_SUM:
            begin
                if (status.out_free)
                begin
                    cmd.sum_load = 1'b1;
                    cmd.advance  = 1'b1;
                    if (status.last_out)
                    begin
                        cmd.finish = 1'b1;
                        state_next = vslr_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = vslr_pkg::S_MUL1;
                    end
                end
            end
            default:
            begin
                state_next = vslr_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == vslr_pkg::S_DECIDE))
        else $error("accepted item not followed by decision");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_load |-> status.out_free)
        else $error("output register overwritten");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vslr_pkg::S_DIV) |=> (state_reg == vslr_pkg::S_FIX))
        else $error("divide not followed by correction");
`endif

endmodule

### rtl/variable_speed_linear_resampler_core.sv
// ----------------------------------------------------------------------------
// variable_speed_linear_resampler_core
// Stereo linear-interpolation resampler with speed in hundredths of a frame.
// ----------------------------------------------------------------------------
//
//  channel   handshake                   payload
//  -------   -------------------------   ----------------------------------
//  input     in_valid / in_ready         sample_left, sample_right
//  output    out_valid / out_ready       out_left, out_right, last_of_run
//  config    psel, penable, pwrite       paddr, pwdata, prdata (pready high)
//
//  a frame after the first passes through the decide state, the reciprocal
//  divide of the frame difference by 100 and its floor correction, then
//  for each output through two multiplier stages and the load
//  the first frame and a frame that gives no output return to idle from
//  the decide state
//  reset: speed 100, position zero, no frame seen, output register empty
//  a full output register stalls the sequencer before each load; the next
//  item is taken while the final output of a frame still waits
//
// ----------------------------------------------------------------------------
module variable_speed_linear_resampler_core #(
    parameter int SAMPLE_BITS = vslr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vslr_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [vslr_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [vslr_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    // source frames
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_left,
    input  logic signed [SAMPLE_BITS-1:0]         sample_right,
    // output frames
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         out_left,
    output logic signed [SAMPLE_BITS-1:0]         out_right,
    output logic                                  last_of_run
);

    vslr_pkg::vslr_cmd_t                 cmd;
    vslr_pkg::vslr_status_t              status;

    // speed register, raw value; clamping to 2..200 happens in the datapath
    logic [vslr_pkg::SPEED_BITS-1:0]     speed_reg, speed_next;
    logic                                wr_en;

    // register index sits at paddr[2], byte offset bits ignored
    assign wr_en  = psel && penable && pwrite && pready
                 && (paddr[2] == vslr_pkg::REG_SPEED);
    assign pready = 1'b1;

    assign speed_next = wr_en ? pwdata[vslr_pkg::SPEED_BITS-1:0] : speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= vslr_pkg::SPEED_RESET;
        else
            speed_reg <= speed_next;
    end

    // read back; unmapped addresses read as zero
    always_comb
    begin
        if (paddr[2] == vslr_pkg::REG_SPEED)
            prdata = {{(vslr_pkg::APB_DATA_BITS-vslr_pkg::SPEED_BITS){1'b0}}, speed_reg};
        else
            prdata = '0;
    end

    // sequencer
    vslr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // position, channel arithmetic and output register
    vslr_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .speed        (speed_reg),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_left     (out_left),
        .out_right    (out_right),
        .last_of_run  (last_of_run)
    );

endmodule
